// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while in reset.
`define MPD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that is also required during reset.
`define MPD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/mpd_pkg.sv =====
// Types, codes and helpers of the program stream demultiplexer.
package mpd_pkg;
	localparam int QueueDepthDefault = 4;

	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_STAMP   = 3'd1;
	localparam logic [2:0] KIND_MARKER  = 3'd2;
	localparam logic [2:0] KIND_DONE    = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic REG_AUDIO_SELECT = 1'b0;
	localparam logic REG_VIDEO_SELECT = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        channel;
		logic [7:0]  payload;
		logic [1:0]  stamp_flags;
		logic [32:0] present_stamp;
		logic [32:0] decode_stamp;
	} mpd_rec_t;

	typedef struct packed {
		logic push;
		logic push_final;
		logic stopped;
	} mpd_stat_t;

	// Feed one stamp byte k (0..4) into the accumulator.
	function automatic logic [32:0] ts_feed(input logic [32:0] acc, input logic [3:0] k,
		input logic [7:0] b);
		logic [40:0] wide;
		begin
			wide = '0;
			if (k == 4'd0) begin
				wide = {38'd0, b[3:1]};
			end else if (k == 4'd1 || k == 4'd3) begin
				wide = {acc, b};
			end else begin
				wide = {1'b0, acc, b[7:1]};
			end
			ts_feed = wide[32:0];
		end
	endfunction
endpackage

// ===== rtl/core/mpd_if.sv =====
// Channel interfaces: input bytes, result records and register writes.
interface mpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       end_of_input;
	modport source (output valid, stream_byte, end_of_input, input ready);
	modport sink (input valid, stream_byte, end_of_input, output ready);
endinterface

interface mpd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic        channel;
	logic [7:0]  payload;
	logic [1:0]  stamp_flags;
	logic [32:0] present_stamp;
	logic [32:0] decode_stamp;
	modport source (output valid, kind, channel, payload, stamp_flags, present_stamp,
		decode_stamp, input ready);
	modport sink (input valid, kind, channel, payload, stamp_flags, present_stamp,
		decode_stamp, output ready);
endinterface

interface mpd_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [4:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mpd_front.sv =====
// Byte parser: start code search, header decode, record generation.
module mpd_front import mpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mpd_in_if.sink     in_ch,
	mpd_cfg_if.sink    cfg,
	input  logic       room,
	output mpd_rec_t   rec,
	output mpd_stat_t  stat
);
	localparam logic [3:0] PH_SEARCH    = 4'd0;
	localparam logic [3:0] PH_ID        = 4'd1;
	localparam logic [3:0] PH_PACK_VER  = 4'd2;
	localparam logic [3:0] PH_PACK_SKIP = 4'd3;
	localparam logic [3:0] PH_LEN_HI    = 4'd4;
	localparam logic [3:0] PH_LEN_LO    = 4'd5;
	localparam logic [3:0] PH_SKIP      = 4'd6;
	localparam logic [3:0] PH_PES_FIRST = 4'd7;
	localparam logic [3:0] PH_STUFF     = 4'd8;
	localparam logic [3:0] PH_STD2      = 4'd9;
	localparam logic [3:0] PH_FLAG      = 4'd10;
	localparam logic [3:0] PH_TS        = 4'd11;
	localparam logic [3:0] PH_M2_FLAGS  = 4'd12;
	localparam logic [3:0] PH_M2_HLEN   = 4'd13;
	localparam logic [3:0] PH_M2_SKIP   = 4'd14;
	localparam logic [3:0] PH_PAYLOAD   = 4'd15;

	logic [4:0]  audio_q;
	logic [3:0]  video_q;
	logic [3:0]  phase_q, phase_n;
	logic [1:0]  zrun_q, zrun_n;
	logic [7:0]  id_q, id_n;
	logic [16:0] pos_q, pos_n;
	logic [16:0] total_q, total_n;
	logic [7:0]  skip_q, skip_n;
	logic [1:0]  flag_q, flag_n;
	logic [32:0] pts_q, pts_n;
	logic [32:0] dts_q, dts_n;
	logic [1:0]  ver_q, ver_n;
	logic        stop_q, stop_n;

	logic        take, emit, halt, ch;
	logic [7:0]  b;
	logic [17:0] pos_inc;
	logic [3:0]  left;
	logic [3:0]  left_dec;

	assign take = in_ch.valid & in_ch.ready;
	assign in_ch.ready = room;
	assign cfg.ready = 1'b1;
	assign b = in_ch.stream_byte;
	assign ch = (id_q >= 8'he0);
	assign pos_inc = {1'b0, pos_q} + 18'd1;

	always_comb begin
		phase_n = phase_q; zrun_n = zrun_q; id_n = id_q; pos_n = pos_q;
		total_n = total_q; skip_n = skip_q; flag_n = flag_q; pts_n = pts_q;
		dts_n = dts_q; ver_n = ver_q; stop_n = stop_q;
		emit = 1'b0; halt = 1'b0; rec = '0;
		left = 4'd1; left_dec = 4'd0;
		if (take && !stop_q) begin
			if (in_ch.end_of_input) begin
				halt = 1'b1; emit = 1'b1; rec.kind = KIND_DONE;
			end else if (phase_q == PH_SEARCH) begin
				if (b == 8'h00) begin
					if (zrun_q < 2'd2) zrun_n = zrun_q + 2'd1;
				end else if (b == 8'h01 && zrun_q == 2'd2) begin
					phase_n = PH_ID; zrun_n = 2'd0;
				end else begin
					zrun_n = 2'd0;
				end
			end else if (phase_q == PH_ID) begin
				id_n = b;
				pos_n = 17'd4;
				if (b <= 8'hb9) begin
					halt = 1'b1; emit = 1'b1; rec.kind = KIND_DONE;
				end else if (b == 8'hba) begin
					phase_n = PH_PACK_VER; total_n = 17'd14;
				end else begin
					phase_n = PH_LEN_HI; total_n = 17'd6;
				end
			end else begin
				case (phase_q)
					PH_PACK_VER: begin
						if (b[7:6] == 2'b01) begin
							ver_n = 2'd2; phase_n = PH_PACK_SKIP;
						end else if (b[7:4] == 4'h2) begin
							ver_n = 2'd1; total_n = 17'd12; phase_n = PH_PACK_SKIP;
						end else begin
							halt = 1'b1; emit = 1'b1; rec.kind = KIND_ERROR;
						end
					end
					PH_PACK_SKIP: begin
						if (ver_q == 2'd2 && pos_q == 17'd13)
							total_n = total_q + {14'd0, b[2:0]};
					end
					PH_LEN_HI: begin
						total_n = {1'b0, b, 8'd0} + 17'd6;
						phase_n = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						total_n = total_q + {9'd0, b};
						if ((id_q[7:5] == 3'b110 && id_q[4:0] == audio_q) ||
							(id_q[7:4] == 4'he && id_q[3:0] == video_q))
							phase_n = PH_PES_FIRST;
						else
							phase_n = PH_SKIP;
					end
					PH_SKIP: begin
					end
					PH_PES_FIRST, PH_STUFF, PH_FLAG: begin
						if (phase_q == PH_PES_FIRST && b[7:6] == 2'b10) begin
							phase_n = PH_M2_FLAGS;
							emit = 1'b1; rec.kind = KIND_MARKER; rec.channel = ch;
						end else if (phase_q != PH_FLAG && b == 8'hff) begin
							phase_n = PH_STUFF;
						end else if (phase_q != PH_FLAG && b[7:6] == 2'b01) begin
							phase_n = PH_STD2;
						end else if (b[7:4] == 4'h0) begin
							// flag byte with no stamps ends the header
							flag_n = 2'd0; phase_n = PH_PAYLOAD;
							if (pos_inc < {1'b0, total_q}) begin
								emit = 1'b1; rec.kind = KIND_STAMP; rec.channel = ch;
							end
						end else if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
							flag_n = b[5:4];
							pts_n = ts_feed(33'd0, 4'd0, b);
							skip_n = (b[4]) ? 8'd9 : 8'd4;
							phase_n = PH_TS;
						end else begin
							halt = 1'b1; emit = 1'b1; rec.kind = KIND_ERROR;
						end
					end
					PH_STD2: phase_n = PH_FLAG;
					PH_TS: begin
						left = (skip_q == 8'd0 || skip_q > 8'd9) ? 4'd1 : skip_q[3:0];
						if (flag_q == 2'd3 && left >= 4'd6)
							pts_n = ts_feed(pts_q, 4'd10 - left, b);
						else if (flag_q == 2'd3)
							dts_n = ts_feed(dts_q, 4'd5 - left, b);
						else if (left <= 4'd4)
							pts_n = ts_feed(pts_q, 4'd5 - left, b);
						left_dec = left - 4'd1;
						skip_n = {4'd0, left_dec};
						if (left_dec == 4'd0) begin
							phase_n = PH_PAYLOAD;
							if (pos_inc < {1'b0, total_q}) begin
								emit = 1'b1; rec.kind = KIND_STAMP; rec.channel = ch;
								rec.stamp_flags = flag_q;
								rec.present_stamp = (flag_q >= 2'd2) ? pts_n : 33'd0;
								rec.decode_stamp = (flag_q == 2'd3) ? dts_n : 33'd0;
							end
						end
					end
					PH_M2_FLAGS: phase_n = PH_M2_HLEN;
					PH_M2_HLEN: begin
						skip_n = b;
						phase_n = (b == 8'd0) ? PH_PAYLOAD : PH_M2_SKIP;
					end
					PH_M2_SKIP: begin
						if (skip_q > 8'd0) skip_n = skip_q - 8'd1;
						if (skip_n == 8'd0) phase_n = PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						emit = 1'b1; rec.kind = KIND_PAYLOAD; rec.channel = ch; rec.payload = b;
					end
					default: begin
						phase_n = PH_SEARCH;
					end
				endcase
				if (!halt) begin
					pos_n = pos_inc[16:0];
					if (pos_inc >= {1'b0, total_n}) begin
						phase_n = PH_SEARCH; zrun_n = 2'd0;
					end
				end
			end
			if (halt) begin
				stop_n = 1'b1; phase_n = PH_SEARCH; zrun_n = 2'd0;
			end
		end
	end

	assign stat.push = emit;
	assign stat.push_final = emit & halt;
	assign stat.stopped = stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_q <= '0; video_q <= '0; phase_q <= PH_SEARCH; zrun_q <= '0;
			id_q <= '0; pos_q <= '0; total_q <= '0; skip_q <= '0; flag_q <= '0;
			pts_q <= '0; dts_q <= '0; ver_q <= '0; stop_q <= 1'b0;
		end else begin
			phase_q <= phase_n; zrun_q <= zrun_n; id_q <= id_n; pos_q <= pos_n;
			total_q <= total_n; skip_q <= skip_n; flag_q <= flag_n; pts_q <= pts_n;
			dts_q <= dts_n; ver_q <= ver_n; stop_q <= stop_n;
			if (cfg.valid) begin
				if (cfg.index == REG_AUDIO_SELECT) audio_q <= cfg.data;
				if (cfg.index == REG_VIDEO_SELECT) video_q <= cfg.data[3:0];
			end
		end
	end
endmodule

// ===== rtl/core/mpd_queue.sv =====
// Record queue between the parser and the output channel.
module mpd_queue import mpd_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mpd_rec_t  rec,
	output logic      room,
	mpd_out_if.source out_ch
);
	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

	mpd_rec_t        mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;
	logic            pop;
	mpd_rec_t        head;

	assign room = (cnt_q != FullCnt);
	assign pop = out_ch.valid & out_ch.ready;
	assign head = mem_q[rd_q];
	assign out_ch.valid = (cnt_q != '0);
	assign out_ch.kind = head.kind;
	assign out_ch.channel = head.channel;
	assign out_ch.payload = head.payload;
	assign out_ch.stamp_flags = head.stamp_flags;
	assign out_ch.present_stamp = head.present_stamp;
	assign out_ch.decode_stamp = head.decode_stamp;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
			if (pop) rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
			if (push && !pop) cnt_q <= cnt_q + CntW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
		end
	end
endmodule

// ===== rtl/core/mpeg_ps_demux.sv =====
// Top level of the MPEG program stream demultiplexer.
// in_ch carries one stream byte per transfer, with end_of_input marking the
// end of the source. out_ch carries result records: payload bytes, stamp
// headers, MPEG-2 markers and a final done or error record. cfg writes
// audio_select (index 0) and video_select (index 1); it is always ready.
// Throughput: one byte per cycle while the queue has a free slot; the parser
// updates all its state for each byte it takes. A record produced by a byte is
// written into the queue and shows on out_ch once the records ahead of it leave.
// Records wait in a QueueDepth-entry queue; when out_ch stalls and the queue
// fills, in_ch.ready drops until a record leaves. Bytes that produce no
// record still need a free slot to be taken.
// Reset clears the parser to start-code search, both selects to zero and
// empties the queue. After a done or error record, bytes are taken and
// dropped until the next reset.
`include "assert_macros.svh"
module mpeg_ps_demux import mpd_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	mpd_in_if.sink    in_ch,
	mpd_cfg_if.sink   cfg,
	mpd_out_if.source out_ch
);
	mpd_rec_t  rec;
	mpd_stat_t stat;
	logic      room;

	mpd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg),
		.room(room), .rec(rec), .stat(stat)
	);

	mpd_queue #(.QueueDepth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(stat.push), .rec(rec),
		.room(room), .out_ch(out_ch)
	);

	`MPD_ASSERT(a_final_stops, clk, arst_n, stat.push_final |=> stat.stopped, "final record without stop")
	`MPD_ASSERT(a_stop_sticky, clk, arst_n, stat.stopped |=> stat.stopped, "stop flag cleared")
	`MPD_ASSERT(a_no_push_stopped, clk, arst_n, stat.stopped |-> !stat.push, "record after stop")
	`MPD_ASSERT_ALWAYS(a_stall_full, clk, !in_ch.ready |-> out_ch.valid, "input stalled with empty queue")
endmodule
